/* sv/xdrle_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// XOR delta RLE decoder package
// Shared constants, reply codes and the result beat type.
// ----------------------------------------------------------------------------
package xdrle_pkg;

  localparam int unsigned MaxFrameBytes = 65536;
  localparam int unsigned StoreAw       = $clog2(MaxFrameBytes);
  localparam int unsigned PosW          = 17;
  localparam int unsigned ByteW         = 8;
  localparam int unsigned AddrW         = 16;

  localparam logic [PosW-1:0]  MaxFrameSize = PosW'(MaxFrameBytes);
  localparam logic [PosW-1:0]  FrameReset   = PosW'(65536);
  localparam logic [ByteW-1:0] ZeroRunLen   = ByteW'(255);

  localparam logic OpStream = 1'b0;
  localparam logic OpRead   = 1'b1;

  localparam logic KindRead = 1'b0;
  localparam logic KindDone = 1'b1;

  typedef struct packed {
    logic              reply_kind;
    logic [ByteW-1:0]  read_data;
    logic [PosW-1:0]   covered_count;
    logic              frame_short;
  } res_t;

endpackage
`default_nettype wire

/* sv/xdrle_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// XOR delta RLE decoder frame RAM
// Simple dual-port synchronous RAM with one write port and one registered
// read port.
// ----------------------------------------------------------------------------
module xdrle_ram #(
  parameter int unsigned Depth = 65536,
  parameter int unsigned Width = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

/* sv/xdrle_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// XOR delta RLE decoder sequencer
// Pairs count and value bytes, runs the read-modify-write loop over the
// frame RAM, serves reads and builds the result beats.
// ----------------------------------------------------------------------------
module xdrle_ctrl (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic                           operation_i,
  input  wire logic [xdrle_pkg::ByteW-1:0]    stream_byte_i,
  input  wire logic                           end_of_frame_i,
  input  wire logic [xdrle_pkg::AddrW-1:0]    read_address_i,
  input  wire logic                           cfg_we_i,
  input  wire logic [xdrle_pkg::PosW-1:0]     cfg_wdata_i,
  output logic                                res_valid_o,
  output xdrle_pkg::res_t                     res_o,
  input  wire logic                           res_stall_i,
  output logic                                ram_we_o,
  output logic      [xdrle_pkg::StoreAw-1:0]  ram_waddr_o,
  output logic      [xdrle_pkg::ByteW-1:0]    ram_wdata_o,
  output logic                                ram_re_o,
  output logic      [xdrle_pkg::StoreAw-1:0]  ram_raddr_o,
  input  wire logic [xdrle_pkg::ByteW-1:0]    ram_rdata_i
);
  import xdrle_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRead = 2'd1;
  localparam logic [1:0] StRun  = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [PosW-1:0]    cfg_q;
  logic [PosW-1:0]    pos_q, pos_d;
  logic [PosW-1:0]    hwm_q, hwm_d;
  logic [ByteW-1:0]   held_q, held_d;
  logic               held_vld_q, held_vld_d;
  logic [ByteW-1:0]   val_q, val_d;
  logic [ByteW-1:0]   rem_q, rem_d;
  logic               last_q, last_d;
  logic               fresh_q, fresh_d;
  logic               wr_pend_q, wr_pend_d;
  logic [StoreAw-1:0] wr_addr_q, wr_addr_d;
  logic               res_vld_q, res_vld_d;
  res_t               res_q, res_d;

  logic [PosW-1:0]    limit;
  logic [ByteW-1:0]   old_byte;
  logic               accept;
  logic               issue;
  res_t               done_res;

  assign limit      = (cfg_q > MaxFrameSize) ? MaxFrameSize : cfg_q;
  assign old_byte   = fresh_q ? '0 : ram_rdata_i;
  assign in_stall_o = (state_q != StIdle) || res_vld_q;
  assign accept     = in_valid_i && !in_stall_o;
  assign issue      = (rem_q != '0) && (pos_q < limit);

  assign done_res.reply_kind    = KindDone;
  assign done_res.read_data     = '0;
  assign done_res.covered_count = pos_q;
  assign done_res.frame_short   = pos_q < limit;

  assign ram_we_o    = wr_pend_q;
  assign ram_waddr_o = wr_addr_q;
  assign ram_wdata_o = old_byte ^ val_q;

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

  always_comb begin
    state_d    = state_q;
    pos_d      = pos_q;
    hwm_d      = hwm_q;
    held_d     = held_q;
    held_vld_d = held_vld_q;
    val_d      = val_q;
    rem_d      = rem_q;
    last_d     = last_q;
    fresh_d    = fresh_q;
    wr_pend_d  = 1'b0;
    wr_addr_d  = wr_addr_q;
    res_vld_d  = res_vld_q && res_stall_i;
    res_d      = res_q;
    ram_re_o   = 1'b0;
    ram_raddr_o = read_address_i[StoreAw-1:0];

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (operation_i == OpRead) begin
            ram_re_o = 1'b1;
            fresh_d  = {1'b0, read_address_i} >= hwm_q;
            state_d  = StRead;
          end else if (!held_vld_q) begin
            held_d     = stream_byte_i;
            held_vld_d = !end_of_frame_i;
            if (end_of_frame_i) begin
              held_d    = '0;
              res_vld_d = 1'b1;
              res_d     = done_res;
              pos_d     = '0;
            end
          end else begin
            val_d      = stream_byte_i;
            rem_d      = (held_q == '0) ? ZeroRunLen : held_q;
            last_d     = end_of_frame_i;
            held_d     = '0;
            held_vld_d = 1'b0;
            state_d    = StRun;
          end
        end
      end
      StRead: begin
        res_vld_d            = 1'b1;
        res_d.reply_kind     = KindRead;
        res_d.read_data      = old_byte;
        res_d.covered_count  = '0;
        res_d.frame_short    = 1'b0;
        state_d              = StIdle;
      end
      StRun: begin
        if (issue) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = pos_q[StoreAw-1:0];
          fresh_d     = pos_q >= hwm_q;
          if (pos_q >= hwm_q) begin
            hwm_d = pos_q + PosW'(1);
          end
          pos_d     = pos_q + PosW'(1);
          rem_d     = rem_q - ByteW'(1);
          wr_pend_d = 1'b1;
          wr_addr_d = pos_q[StoreAw-1:0];
        end else begin
          state_d = StIdle;
          if (last_q) begin
            res_vld_d = 1'b1;
            res_d     = done_res;
            pos_d     = '0;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      cfg_q      <= FrameReset;
      pos_q      <= '0;
      hwm_q      <= '0;
      held_q     <= '0;
      held_vld_q <= 1'b0;
      wr_pend_q  <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      pos_q      <= pos_d;
      hwm_q      <= hwm_d;
      held_q     <= held_d;
      held_vld_q <= held_vld_d;
      wr_pend_q  <= wr_pend_d;
      res_vld_q  <= res_vld_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q     <= val_d;
    rem_q     <= rem_d;
    last_q    <= last_d;
    fresh_q   <= fresh_d;
    wr_addr_q <= wr_addr_d;
    res_q     <= res_d;
  end

endmodule
`default_nettype wire

/* sv/xdrle_out.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// XOR delta RLE decoder output stage
// Output register that holds a result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module xdrle_out (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         res_valid_i,
  input  wire xdrle_pkg::res_t              res_i,
  output logic                              res_stall_o,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic                              reply_kind_o,
  output logic      [xdrle_pkg::ByteW-1:0]  read_data_o,
  output logic      [xdrle_pkg::PosW-1:0]   covered_count_o,
  output logic                              frame_short_o
);
  import xdrle_pkg::*;

  logic out_vld_q, out_vld_d;
  res_t out_q;
  logic load;

  assign res_stall_o = out_vld_q && out_stall_i;
  assign load        = res_valid_i && !res_stall_o;
  assign out_vld_d   = load || (out_vld_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res_i;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign reply_kind_o    = out_q.reply_kind;
  assign read_data_o     = out_q.read_data;
  assign covered_count_o = out_q.covered_count;
  assign frame_short_o   = out_q.frame_short;

endmodule
`default_nettype wire

/* sv/xor_delta_rle_frame_decoder.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// XOR delta RLE frame decoder
// Decodes (count, value) byte pairs into a stored frame by XOR and serves
// byte reads of that frame.
// ----------------------------------------------------------------------------
// A count byte is held until its value byte arrives. A value byte stalls the
// input while its run, at most 255 frame bytes, is written; the single
// read and single write port of the frame RAM handle one byte per cycle in a
// pipelined read-modify-write loop. A read goes through the registered RAM
// read port. Every beat that produces a result beat, a read or a byte flagged
// last, holds the input while the result moves into the output register,
// and longer while that register is full and stalled. A
// high-water mark makes never-written bytes read as zero, so there is no
// clearing pass after reset and the block is usable at once. One finished
// result beat can wait in the output register while the next input beat is
// taken and processed.
// ----------------------------------------------------------------------------
module xor_delta_rle_frame_decoder (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         operation_i,
  input  wire logic [xdrle_pkg::ByteW-1:0]  stream_byte_i,
  input  wire logic                         end_of_frame_i,
  input  wire logic [xdrle_pkg::AddrW-1:0]  read_address_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [xdrle_pkg::PosW-1:0]   cfg_wdata_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic                              reply_kind_o,
  output logic      [xdrle_pkg::ByteW-1:0]  read_data_o,
  output logic      [xdrle_pkg::PosW-1:0]   covered_count_o,
  output logic                              frame_short_o
);
  import xdrle_pkg::*;

  logic               res_valid;
  res_t               res;
  logic               res_stall;
  logic               ram_we;
  logic [StoreAw-1:0] ram_waddr;
  logic [ByteW-1:0]   ram_wdata;
  logic               ram_re;
  logic [StoreAw-1:0] ram_raddr;
  logic [ByteW-1:0]   ram_rdata;

  xdrle_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .stream_byte_i  (stream_byte_i),
    .end_of_frame_i (end_of_frame_i),
    .read_address_i (read_address_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .res_valid_o    (res_valid),
    .res_o          (res),
    .res_stall_i    (res_stall),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_re_o       (ram_re),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata)
  );

  xdrle_ram #(
    .Depth (MaxFrameBytes),
    .Width (ByteW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  xdrle_out u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .res_valid_i     (res_valid),
    .res_i           (res),
    .res_stall_o     (res_stall),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .reply_kind_o    (reply_kind_o),
    .read_data_o     (read_data_o),
    .covered_count_o (covered_count_o),
    .frame_short_o   (frame_short_o)
  );

endmodule
`default_nettype wire

/* sv/xdrle_chk.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// XOR delta RLE decoder port checker
// Concurrent checks on the top-level ports, bound to the decoder.
// ----------------------------------------------------------------------------
module xdrle_chk (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         out_valid_o,
  input wire logic                         out_stall_i,
  input wire logic                         reply_kind_o,
  input wire logic [xdrle_pkg::ByteW-1:0]  read_data_o,
  input wire logic [xdrle_pkg::PosW-1:0]   covered_count_o,
  input wire logic                         frame_short_o
);
  import xdrle_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(reply_kind_o)
      && $stable(read_data_o) && $stable(covered_count_o))
    else $error("Stalled result beat changed.");

  a_read_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (reply_kind_o == KindRead) |->
      (covered_count_o == '0) && !frame_short_o)
    else $error("Read reply carries completion fields.");

  a_done_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (reply_kind_o == KindDone) |-> (read_data_o == '0))
    else $error("Completion report carries read data.");

  a_cover_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (reply_kind_o == KindDone) |-> (covered_count_o <= MaxFrameSize))
    else $error("Covered count exceeds the frame store.");

endmodule

bind xor_delta_rle_frame_decoder xdrle_chk u_chk (.*);
`default_nettype wire
